[src/lca_pkg.sv]
// Shared constants, types and helpers for the lowest common ancestor block.
package lca_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int LOG_LEVELS = 12;
    localparam int ID_W       = 12;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int LVL_W      = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int DIFF_W     = LOG_LEVELS;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LOG_LEVELS-1:0][NODE_W-1:0] lvl_arr_t;

    // One memory row: the node's depth and all of its jump levels.
    typedef struct packed {
        node_t    depth;
        lvl_arr_t lvl;
    } row_t;

    typedef struct packed {
        node_t rd_addr_a;
        node_t rd_addr_b;
        logic  we;
        node_t wr_addr;
        row_t  wr_data;
    } ram_req_t;

    typedef struct packed {
        logic  valid;
        node_t id;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_DEPTH,
        ST_Q_LIFT,
        ST_Q_CMP,
        ST_Q_SEARCH,
        ST_Q_FINAL,
        ST_RESULT,
        ST_A_WALK,
        ST_A_WRITE
    } state_t;

    // Ids outside the tree stand for node 0.
    function automatic node_t clamp_id(input logic [ID_W-1:0] id);
        node_t n;
        n = '0;
        if (int'(id) < MAX_NODES) begin
            n = NODE_W'(id);
        end
        return n;
    endfunction

endpackage

[src/lca_row_ram.sv]
// Row memory holding depth and jump table, one write port and two registered read ports.
module lca_row_ram (
    input  logic              aclk,
    input  lca_pkg::ram_req_t req,
    output lca_pkg::row_t     rd_a,
    output lca_pkg::row_t     rd_b
);
    import lca_pkg::*;

    row_t mem [MAX_NODES];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_a <= mem[req.rd_addr_a];
        rd_b <= mem[req.rd_addr_b];
    end

endmodule

[src/lca_ctrl.sv]
// Sequencer for table clearing, node insertion and ancestor queries.
module lca_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [lca_pkg::ID_W-1:0] s_node_id,
    input  logic [lca_pkg::ID_W-1:0] s_peer_id,
    input  logic                  out_free,
    output lca_pkg::result_t      res,
    output lca_pkg::ram_req_t     ram_req,
    input  lca_pkg::row_t         rd_a,
    input  lca_pkg::row_t         rd_b
);
    import lca_pkg::*;

    state_t            state_reg, state_next;
    node_t             clr_reg, clr_next;
    node_t             u_reg, u_next;
    node_t             v_reg, v_next;
    node_t             node_reg, node_next;
    node_t             depth_reg, depth_next;
    node_t             res_reg, res_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [DIFF_W-1:0] diff_reg, diff_next;
    lvl_arr_t          built_reg, built_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        u_reg     <= u_next;
        v_reg     <= v_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        res_reg   <= res_next;
        lvl_reg   <= lvl_next;
        diff_reg  <= diff_next;
        built_reg <= built_next;
    end

    always_comb begin
        node_t            a_val;
        node_t            b_val;
        node_t            fwd;
        logic [LVL_W-1:0] lvl_prev;

        state_next = state_reg;
        clr_next   = clr_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        node_next  = node_reg;
        depth_next = depth_reg;
        res_next   = res_reg;
        lvl_next   = lvl_reg;
        diff_next  = diff_reg;
        built_next = built_reg;
        s_ready    = 1'b0;
        res.valid  = 1'b0;
        res.id     = res_reg;
        ram_req.we      = 1'b0;
        ram_req.wr_addr = node_reg;
        ram_req.wr_data = '{depth: depth_reg, lvl: built_reg};
        a_val    = rd_a.lvl[lvl_reg];
        b_val    = rd_b.lvl[lvl_reg];
        lvl_prev = lvl_reg - 1'b1;
        fwd      = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = clr_reg;
                ram_req.wr_data = '0;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == NODE_W'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_QUERY) begin
                        u_next     = clamp_id(s_node_id);
                        v_next     = clamp_id(s_peer_id);
                        state_next = ST_Q_DEPTH;
                    end else if (s_node_id != '0 && int'(s_node_id) < MAX_NODES) begin
                        node_next     = NODE_W'(s_node_id);
                        built_next    = '0;
                        built_next[0] = clamp_id(s_peer_id);
                        u_next        = clamp_id(s_peer_id);
                        lvl_next      = LVL_W'(1);
                        state_next    = ST_A_WALK;
                    end
                end
            end
            ST_Q_DEPTH: begin
                // The deeper node climbs; re-read both rows in the swapped order.
                if (rd_a.depth < rd_b.depth) begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = DIFF_W'(rd_b.depth - rd_a.depth);
                end else begin
                    diff_next = DIFF_W'(rd_a.depth - rd_b.depth);
                end
                lvl_next   = LVL_W'(LOG_LEVELS - 1);
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT: begin
                if (diff_reg[lvl_reg]) begin
                    u_next = a_val;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_Q_CMP;
                end else begin
                    lvl_next = lvl_prev;
                end
            end
            ST_Q_CMP: begin
                if (u_reg == v_reg) begin
                    res_next   = u_reg;
                    state_next = ST_RESULT;
                end else begin
                    lvl_next   = LVL_W'(LOG_LEVELS - 1);
                    state_next = ST_Q_SEARCH;
                end
            end
            ST_Q_SEARCH: begin
                if (a_val != b_val) begin
                    u_next = a_val;
                    v_next = b_val;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_Q_FINAL;
                end else begin
                    lvl_next = lvl_prev;
                end
            end
            ST_Q_FINAL: begin
                res_next   = rd_a.lvl[0];
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_A_WALK: begin
                // The first read returns the parent's row, which carries its depth.
                if (lvl_reg == LVL_W'(1)) begin
                    if (rd_a.depth == NODE_W'(MAX_NODES - 1)) begin
                        depth_next = rd_a.depth;
                    end else begin
                        depth_next = rd_a.depth + 1'b1;
                    end
                end
                // When the walk reaches the node being rewritten, its new row
                // is still in registers and takes the place of the memory data.
                if (built_reg[lvl_prev] == node_reg) begin
                    fwd = built_reg[lvl_prev];
                end else begin
                    fwd = rd_a.lvl[lvl_prev];
                end
                built_next[lvl_reg] = fwd;
                u_next              = fwd;
                if (lvl_reg == LVL_W'(LOG_LEVELS - 1)) begin
                    state_next = ST_A_WRITE;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_A_WRITE: begin
                ram_req.we = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ram_req.rd_addr_a = u_next;
        ram_req.rd_addr_b = v_next;
    end

endmodule

[src/lca_binary_lifting_top.sv]
// Lowest common ancestor by binary lifting: tree memory, sequencer and result register.
//
// The tree lives in one row memory of 4096 rows, each holding a node's depth
// and its 12 jump levels; after reset a clearing pass writes one row per cycle,
// and no item is transferred until it ends. An add transfer (op 0) walks the
// jump levels one memory read per cycle and then writes the new row, and gives
// no result; adding node 0 returns at once. A query transfer (op 1) runs as one
// read for both depths, 12 lifting steps, one compare, 12 search steps and a
// final read, each step waiting on the registered read of the row memory; when
// the lifted node already equals the other one, the search is skipped. One
// item is worked on at a time; the result register lets the next item be
// transferred while a result still waits on m_ready.
module lca_binary_lifting_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [lca_pkg::ID_W-1:0]  s_node_id,
    input  logic [lca_pkg::ID_W-1:0]  s_peer_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [lca_pkg::ID_W-1:0]  m_ancestor_id
);
    import lca_pkg::*;

    ram_req_t         ram_req;
    row_t             rd_a;
    row_t             rd_b;
    result_t          res;
    logic             out_free;
    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_id_reg, m_id_next;

    lca_row_ram u_ram (
        .aclk (aclk),
        .req  (ram_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    lca_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_node_id (s_node_id),
        .s_peer_id (s_peer_id),
        .out_free  (out_free),
        .res       (res),
        .ram_req   (ram_req),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_id_next    = m_id_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res.valid) begin
            m_valid_next = 1'b1;
            m_id_next    = ID_W'(res.id);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_id_reg <= m_id_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_ancestor_id = m_id_reg;

endmodule

[sim/lca_binary_lifting_top_test.sv]
// Self-checking testbench for the binary-lifting lowest common ancestor block.
module lca_binary_lifting_top_test;
    import lca_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int CHAIN_LEN = 1200;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_op = OP_ADD;
    logic [ID_W-1:0] s_node_id = '0;
    logic [ID_W-1:0] s_peer_id = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [ID_W-1:0] m_ancestor_id;

    // Own copy of the tree: depth per node and the jump table.
    node_t tree_depth [MAX_NODES];
    node_t jump_table [MAX_NODES][LOG_LEVELS];
    bit    is_added [MAX_NODES];
    node_t added_ids [$];
    node_t lca_expected [$];

    int unsigned cycle_count = 0;
    int    mismatches = 0;
    logic  steady = 1'b0;
    int    hold_asked = 0;
    int    hold_served = 0;
    int    hold_left = 0;

    lca_binary_lifting_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_node_id     (s_node_id),
        .s_peer_id     (s_peer_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor_id (m_ancestor_id)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL lca_binary_lifting_top");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
    always @(posedge aclk) begin
        if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic report_mismatch(input string what, input node_t want, input node_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
        end
    endtask

    always @(posedge aclk) begin
        node_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lca_expected.size() == 0) begin
                report_mismatch("result with none pending", '0, m_ancestor_id);
            end else begin
                want = lca_expected.pop_front();
                if (m_ancestor_id !== want) begin
                    report_mismatch("ancestor_id", want, m_ancestor_id);
                end
            end
        end
    end

    function automatic void attach_node(input node_t n, input node_t p);
        logic [NODE_W:0] d;
        int i;
        if (n == '0) return;
        d = tree_depth[p] + 1'b1;
        if (d > MAX_NODES - 1) d = MAX_NODES - 1;
        tree_depth[n] = node_t'(d);
        // Levels are filled in order, so a node that is its own parent sees its new entries.
        jump_table[n][0] = p;
        for (i = 1; i < LOG_LEVELS; i++) begin
            jump_table[n][i] = jump_table[jump_table[n][i-1]][i-1];
        end
    endfunction

    function automatic node_t common_ancestor(input node_t u, input node_t v);
        node_t t;
        node_t x;
        node_t y;
        node_t diff;
        int i;
        if (tree_depth[u] < tree_depth[v]) begin
            t = u;
            u = v;
            v = t;
        end
        diff = tree_depth[u] - tree_depth[v];
        for (i = LOG_LEVELS - 1; i >= 0; i--) begin
            if (diff[i]) u = jump_table[u][i];
        end
        if (u == v) return u;
        for (i = LOG_LEVELS - 1; i >= 0; i--) begin
            x = jump_table[u][i];
            y = jump_table[v][i];
            if (x != y) begin
                u = x;
                v = y;
            end
        end
        return jump_table[u][0];
    endfunction

    // Recently added nodes are favored so that the random trees grow deep.
    function automatic node_t pick_known();
        int n;
        n = added_ids.size();
        if (n == 0) return node_t'($urandom_range(1, MAX_NODES - 1));
        if ($urandom_range(0, 1) == 0) begin
            return added_ids[n - 1 - $urandom_range(0, (n < 8) ? n - 1 : 7)];
        end
        return added_ids[$urandom_range(0, n - 1)];
    endfunction

    // Offers one item and returns at the edge where it transfers, valid still high.
    task automatic send_item(input logic op, input node_t nid, input node_t pid);
        if (!steady) begin
            while ($urandom_range(0, 99) < 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_node_id <= nid;
        s_peer_id <= pid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_ADD) begin
            attach_node(nid, pid);
            if (nid != '0 && !is_added[nid]) begin
                is_added[nid] = 1'b1;
                added_ids.push_back(nid);
            end
        end else begin
            lca_expected.push_back(common_ancestor(nid, pid));
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (lca_expected.size() != 0);
    endtask

    task automatic test_directed_tree();
        send_item(OP_ADD, 12'd1, 12'd0);
        send_item(OP_ADD, 12'd2, 12'd1);
        send_item(OP_ADD, 12'd3, 12'd1);
        send_item(OP_ADD, 12'd4095, 12'd2);
        send_item(OP_ADD, 12'd4, 12'd3);
        send_item(OP_ADD, 12'd0, 12'd1);
        send_item(OP_QUERY, 12'd4095, 12'd4);
        send_item(OP_QUERY, 12'd4, 12'd4095);
        send_item(OP_QUERY, 12'd2, 12'd2);
        send_item(OP_QUERY, 12'd4095, 12'd1);
        send_item(OP_QUERY, 12'd1, 12'd0);
        send_item(OP_QUERY, 12'd0, 12'd4095);
        // Nodes never added have the root as parent and the root's depth of 0.
        send_item(OP_QUERY, 12'd100, 12'd200);
        send_item(OP_QUERY, 12'd100, 12'd100);
        send_item(OP_QUERY, 12'd4095, 12'd100);
        // Moving node 2 leaves its old child with stale entries.
        send_item(OP_ADD, 12'd2, 12'd4);
        send_item(OP_QUERY, 12'd4095, 12'd2);
        send_item(OP_QUERY, 12'd2, 12'd4);
        send_item(OP_ADD, 12'd5, 12'd5);
        send_item(OP_QUERY, 12'd5, 12'd1);
        send_item(OP_ADD, 12'd6, 12'd300);
        send_item(OP_QUERY, 12'd6, 12'd300);
        send_item(OP_ADD, 12'd7, 12'd4095);
        send_item(OP_QUERY, 12'd7, 12'd4);
        wait_drain();
    endtask

    task automatic test_random_forest();
        int k;
        int r;
        node_t a;
        node_t b;
        for (k = 0; k < 420; k++) begin
            if (k == 150) steady <= 1'b1;
            if (k == 260) steady <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                if ($urandom_range(0, 3) != 0) a = node_t'($urandom_range(1, MAX_NODES - 1));
                else a = pick_known();
                r = $urandom_range(0, 99);
                if (r < 85) b = pick_known();
                else if (r < 95) b = '0;
                else b = node_t'($urandom_range(0, MAX_NODES - 1));
                send_item(OP_ADD, a, b);
            end else if (r < 88) begin
                a = pick_known();
                r = $urandom_range(0, 99);
                if (r < 10) b = a;
                else if (r < 25) b = jump_table[a][$urandom_range(0, 5)];
                else b = pick_known();
                send_item(OP_QUERY, a, b);
            end else begin
                send_item(1'($urandom_range(0, 1)), node_t'($urandom_range(0, MAX_NODES - 1)),
                          node_t'($urandom_range(0, MAX_NODES - 1)));
            end
        end
        wait_drain();
    endtask

    // The receiver holds off while queries keep coming, so the input must stall.
    task automatic test_output_backpressure();
        int k;
        steady <= 1'b1;
        hold_asked <= hold_asked + 1;
        for (k = 0; k < 40; k++) begin
            send_item(OP_QUERY, pick_known(), pick_known());
        end
        wait_drain();
        steady <= 1'b0;
    endtask

    // A long chain makes the depth differences use the high jump levels.
    task automatic test_deep_chain();
        int k;
        steady <= 1'b1;
        send_item(OP_ADD, 12'd1, 12'd0);
        for (k = 2; k < CHAIN_LEN; k++) begin
            send_item(OP_ADD, node_t'(k), node_t'(k - 1));
        end
        send_item(OP_QUERY, 12'd1199, 12'd1);
        send_item(OP_QUERY, 12'd1199, 12'd600);
        send_item(OP_QUERY, 12'd2, 12'd1198);
        send_item(OP_ADD, 12'd1, 12'd1199);
        send_item(OP_ADD, 12'd1198, 12'd1);
        send_item(OP_QUERY, 12'd1, 12'd1199);
        send_item(OP_QUERY, 12'd1100, 12'd1);
        send_item(OP_QUERY, 12'd1198, 12'd3);
        for (k = 0; k < 20; k++) begin
            send_item(OP_QUERY, node_t'($urandom_range(0, MAX_NODES - 1)),
                      node_t'($urandom_range(0, MAX_NODES - 1)));
        end
        wait_drain();
        steady <= 1'b0;
    endtask

    initial begin
        int i;
        int j;
        for (i = 0; i < MAX_NODES; i++) begin
            tree_depth[i] = '0;
            is_added[i] = 1'b0;
            for (j = 0; j < LOG_LEVELS; j++) jump_table[i][j] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_tree();
        test_random_forest();
        test_output_backpressure();
        test_deep_chain();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && lca_expected.size() == 0) begin
            $display("PASS lca_binary_lifting_top");
        end else begin
            $display("FAIL lca_binary_lifting_top");
        end
        $finish;
    end

endmodule
